### hdl/weighted_quadratic_distance_assert.svh
// Assertion macros shared by the weighted quadratic distance RTL.
`ifndef WEIGHTED_QUADRATIC_DISTANCE_ASSERT_SVH
`define WEIGHTED_QUADRATIC_DISTANCE_ASSERT_SVH

// The check holds in the cycle after the condition, sampled on clk, off during reset.
`define WQD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("weighted quadratic distance check failed");

// The check holds in the same cycle as the condition.
`define WQD_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("weighted quadratic distance check failed");

`endif

### hdl/wqd_pkg.sv
// Shared widths, types, register codes and helpers of the weighted quadratic distance block.
package wqd_pkg;

    localparam int LANES       = 4;
    localparam int DIM_DEFAULT = 4;
    localparam int DATA_W      = 16;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int PROD_W      = DATA_W + DIFF_W;
    localparam int ROW_W       = PROD_W + 2;
    localparam int DIST_W      = 52;
    localparam int CFG_W       = LANES * DATA_W;
    localparam int CFG_IDX_W   = 3;
    localparam int STAGES      = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ROW_W-1:0]  row_t;
    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic [CFG_W-1:0]         cfg_word_t;
    typedef logic [LANES-1:0][CFG_W-1:0] weight_mat_t;
    typedef diff_t [LANES-1:0] diff_vec_t;
    typedef row_t  [LANES-1:0] row_vec_t;
    typedef dist_t [LANES-1:0] dist_vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAN,
        REG_ROW_A,
        REG_ROW_B,
        REG_ROW_C,
        REG_ROW_D
    } cfg_reg_t;

    // Load enables for the two register stages held inside one datapath module.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } pipe_ctrl_t;

    function automatic data_t lane_of(cfg_word_t word, int unsigned lane);
        return data_t'(word[lane*DATA_W +: DATA_W]);
    endfunction

endpackage

### hdl/wqd_cfg_regs.sv
// Configuration register file holding the mean vector and the weight matrix rows.
module wqd_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wqd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wqd_pkg::cfg_word_t           cfg_data,
    output wqd_pkg::cfg_word_t           mean,
    output wqd_pkg::weight_mat_t         weights
);
    import wqd_pkg::*;

    `include "weighted_quadratic_distance_assert.svh"

    cfg_word_t   mean_reg;
    weight_mat_t weight_reg;
    logic        wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;
    assign mean      = mean_reg;
    assign weights   = weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg   <= '0;
            weight_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                REG_MEAN:  mean_reg      <= cfg_data;
                REG_ROW_A: weight_reg[0] <= cfg_data;
                REG_ROW_B: weight_reg[1] <= cfg_data;
                REG_ROW_C: weight_reg[2] <= cfg_data;
                REG_ROW_D: weight_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    `WQD_ASSERT_NEXT(a_mean_write, wr_en && cfg_index == REG_MEAN, mean_reg == $past(cfg_data))

endmodule

### hdl/wqd_row_mac.sv
// Weight-times-difference products and their row sums, two register stages.
module wqd_row_mac
(
    input  logic                     clk,
    input  wqd_pkg::pipe_ctrl_t      ctrl,
    input  wqd_pkg::weight_mat_t     weights,
    input  wqd_pkg::diff_vec_t       diff_in,
    output wqd_pkg::diff_vec_t       diff_out,
    output wqd_pkg::row_vec_t        row_out
);
    import wqd_pkg::*;

    prod_t     prod_reg [LANES][LANES];
    prod_t     prod_next [LANES][LANES];
    diff_vec_t diff_a_reg;
    diff_vec_t diff_b_reg;
    row_vec_t  row_reg;
    row_vec_t  row_next;

    always_comb
    begin
        data_t w;
        diff_t d;
        for (int i = 0; i < LANES; i++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                w = lane_of(weights[i], j);
                d = diff_in[j];
                prod_next[i][j] = PROD_W'(w) * PROD_W'(d);
            end
        end
    end

    always_comb
    begin
        row_t acc;
        for (int i = 0; i < LANES; i++)
        begin
            acc = '0;
            for (int j = 0; j < LANES; j++)
            begin
                acc = acc + ROW_W'(prod_reg[i][j]);
            end
            row_next[i] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            prod_reg   <= prod_next;
            diff_a_reg <= diff_in;
        end
        if (ctrl.load_b)
        begin
            row_reg    <= row_next;
            diff_b_reg <= diff_a_reg;
        end
    end

    assign diff_out = diff_b_reg;
    assign row_out  = row_reg;

endmodule

### hdl/wqd_quad_sum.sv
// Difference-times-row products and the final sum into the output register.
module wqd_quad_sum
(
    input  logic                 clk,
    input  wqd_pkg::pipe_ctrl_t  ctrl,
    input  wqd_pkg::diff_vec_t   diff_in,
    input  wqd_pkg::row_vec_t    row_in,
    output wqd_pkg::dist_t       dist_out
);
    import wqd_pkg::*;

    dist_vec_t term_reg;
    dist_vec_t term_next;
    dist_t     dist_reg;
    dist_t     dist_next;

    always_comb
    begin
        dist_t d;
        dist_t r;
        for (int i = 0; i < LANES; i++)
        begin
            d = DIST_W'(diff_in[i]);
            r = DIST_W'(row_in[i]);
            d = diff_t'(d[DIFF_W-1:0]);
            r = row_t'(r[ROW_W-1:0]);
            term_next[i] = DIST_W'(d * r);
        end
    end

    always_comb
    begin
        dist_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dist_next = dist_next + term_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            term_reg <= term_next;
        end
        if (ctrl.load_b)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

### hdl/weighted_quadratic_distance.sv
// Top level of the weighted quadratic distance block d = (m - y)^T W (m - y).
// An accepted input word moves on from the difference register through the product, row-sum,
// term and sum registers, only as the pipeline advances; the sum register is the output register.
// Throughput: one word per cycle; the five-stage pipeline advances whenever the output is free.
// Reset clears the mean and weight registers to zero and empties every pipeline stage.
module weighted_quadratic_distance
#(
    parameter int DIM = wqd_pkg::DIM_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wqd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wqd_pkg::cfg_word_t            cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wqd_pkg::data_t                obs_lane0,
    input  wqd_pkg::data_t                obs_lane1,
    input  wqd_pkg::data_t                obs_lane2,
    input  wqd_pkg::data_t                obs_lane3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wqd_pkg::dist_t                distance
);
    import wqd_pkg::*;

    `include "weighted_quadratic_distance_assert.svh"

    // The datapath is five register stages:
    //   1. difference m - y per lane (17 bits, exact), here in the top level
    //   2. sixteen products W_ij * diff_j (33 bits)
    //   3. row sums over j (35 bits)
    //   4. diff_i * row_i (52 bits)
    //   5. sum over i, which is the output register
    // The whole pipeline moves together. It holds only while a finished word
    // waits at the output, so a new word enters in every cycle otherwise and
    // nothing is dropped or duplicated during a stall.

    cfg_word_t   mean;
    weight_mat_t weights;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              advance;

    data_t     obs [LANES];
    diff_vec_t diff_next;
    diff_vec_t diff_reg;
    diff_vec_t diff_row;
    row_vec_t  row_sum;

    pipe_ctrl_t row_ctrl;
    pipe_ctrl_t sum_ctrl;

    wqd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mean      (mean),
        .weights   (weights)
    );

    // Advance whenever the output register is empty or being emptied.
    assign advance  = !valid_reg[STAGES-1] || out_ready;
    assign in_ready = advance;

    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign obs[0] = obs_lane0;
    assign obs[1] = obs_lane1;
    assign obs[2] = obs_lane2;
    assign obs[3] = obs_lane3;

    // Lanes at or above DIM carry a zero difference, which also removes
    // their rows and columns of W from the quadratic form.
    for (genvar k = 0; k < LANES; k++)
    begin : g_diff
        if (k < DIM)
        begin : g_used
            assign diff_next[k] = DIFF_W'(lane_of(mean, k)) - DIFF_W'(obs[k]);
        end
        else
        begin : g_unused
            assign diff_next[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            diff_reg <= diff_next;
        end
    end

    // Each stage loads only when a word actually moves into it.
    assign row_ctrl.load_a = advance & valid_reg[0];
    assign row_ctrl.load_b = advance & valid_reg[1];
    assign sum_ctrl.load_a = advance & valid_reg[2];
    assign sum_ctrl.load_b = advance & valid_reg[3];

    wqd_row_mac u_row
    (
        .clk      (clk),
        .ctrl     (row_ctrl),
        .weights  (weights),
        .diff_in  (diff_reg),
        .diff_out (diff_row),
        .row_out  (row_sum)
    );

    wqd_quad_sum u_sum
    (
        .clk      (clk),
        .ctrl     (sum_ctrl),
        .diff_in  (diff_row),
        .row_in   (row_sum),
        .dist_out (distance)
    );

    assign out_valid = valid_reg[STAGES-1];

    `WQD_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, valid_reg[0])
    `WQD_ASSERT_NEXT(a_hold_on_stall, !advance, $stable(valid_reg))
    `WQD_ASSERT_NEXT(a_drain_empties, out_valid && out_ready && !valid_reg[STAGES-2], !out_valid)

endmodule
